FILE: rtl/core/gass_pkg.sv
// ----------------------------------------------------------------------------
// gass_pkg
// Shared constants, types and helpers for the global alignment strip scorer.
// ----------------------------------------------------------------------------
package gass_pkg;

    localparam int STRIP_COLUMNS = 64;
    localparam int REF_DEPTH     = STRIP_COLUMNS - 1;
    localparam int COL_W         = $clog2(STRIP_COLUMNS);
    localparam int CNT_W         = $clog2(STRIP_COLUMNS + 1);
    localparam int PADDR_W       = 5;
    localparam int IDX_W         = PADDR_W - 2;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_ROW   = 2'd1;
    localparam logic [1:0] KIND_BEGIN = 2'd2;

    localparam logic [IDX_W-1:0] REG_MATCH    = 3'd0;
    localparam logic [IDX_W-1:0] REG_MISMATCH = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAP      = 3'd2;
    localparam logic [IDX_W-1:0] REG_OFFSET   = 3'd3;
    localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd4;
    localparam logic [IDX_W-1:0] REG_FIRST    = 3'd5;

    typedef struct packed {
        logic signed [7:0] match_score;
        logic signed [7:0] mismatch_score;
        logic signed [7:0] gap_score;
        logic [23:0]       strip_offset;
        logic [6:0]        strip_width;
        logic              first_strip;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_HEAD,
        S_COLA,
        S_COLB,
        S_DONE,
        S_FILL
    } t_state;

    function automatic logic [31:0] sext8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    function automatic logic [31:0] smax(input logic [31:0] a, input logic [31:0] b);
        return ($signed(a) >= $signed(b)) ? a : b;
    endfunction

endpackage

FILE: rtl/core/gass_in_if.sv
// ----------------------------------------------------------------------------
// gass_in_if
// Input channel: load, row and begin items.
// ----------------------------------------------------------------------------
interface gass_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [7:0]        base;
    logic [5:0]        ref_position;
    logic signed [31:0] left_score;

    modport source (output valid, output kind, output base, output ref_position,
                    output left_score, input ready);
    modport sink   (input valid, input kind, input base, input ref_position,
                    input left_score, output ready);
endinterface

FILE: rtl/core/gass_out_if.sv
// ----------------------------------------------------------------------------
// gass_out_if
// Result channel: row number and rightmost strip score.
// ----------------------------------------------------------------------------
interface gass_out_if;
    logic               valid;
    logic               ready;
    logic [23:0]        row_number;
    logic signed [31:0] right_score;

    modport source (output valid, output row_number, output right_score, input ready);
    modport sink   (input valid, input row_number, input right_score, output ready);
endinterface

FILE: rtl/core/gass_regs.sv
// ----------------------------------------------------------------------------
// gass_regs
// APB configuration registers: scores, strip placement and boundary mode.
// ----------------------------------------------------------------------------
module gass_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gass_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output gass_pkg::t_cfg              o_cfg
);
    import gass_pkg::*;

    t_cfg             r_cfg;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_score    <= 8'sd1;
            r_cfg.mismatch_score <= -8'sd1;
            r_cfg.gap_score      <= -8'sd1;
            r_cfg.strip_offset   <= 24'd0;
            r_cfg.strip_width    <= 7'd64;
            r_cfg.first_strip    <= 1'b1;
        end else if (wr_en) begin
            unique case (idx)
                REG_MATCH:    r_cfg.match_score    <= pwdata[7:0];
                REG_MISMATCH: r_cfg.mismatch_score <= pwdata[7:0];
                REG_GAP:      r_cfg.gap_score      <= pwdata[7:0];
                REG_OFFSET:   r_cfg.strip_offset   <= pwdata[23:0];
                REG_WIDTH:    r_cfg.strip_width    <= pwdata[6:0];
                REG_FIRST:    r_cfg.first_strip    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MATCH:    prdata = sext8(r_cfg.match_score);
            REG_MISMATCH: prdata = sext8(r_cfg.mismatch_score);
            REG_GAP:      prdata = sext8(r_cfg.gap_score);
            REG_OFFSET:   prdata = {8'd0, r_cfg.strip_offset};
            REG_WIDTH:    prdata = {25'd0, r_cfg.strip_width};
            REG_FIRST:    prdata = {31'd0, r_cfg.first_strip};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/core/global_alignment_strip_scorer.sv
// ----------------------------------------------------------------------------
// global_alignment_strip_scorer
// Linear-gap Needleman-Wunsch scorer for one vertical strip of the matrix.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries load, row and begin items; o_out returns one result per row.
//   A load transfer writes one reference base and leaves the channel ready.
//   A begin transfer refills the stored row with (column+offset)*gap and
//   clears the row counter; ready stays low until the refill is done.
//   A row transfer walks columns 1 to W-1 (W = width clamped to 2..STRIP_COLUMNS),
//   each in states S_COLA and S_COLB: ready stays low through S_MUL, S_HEAD, the
//   walk and S_DONE, and the result register is loaded as S_DONE is left.
//   The previous-row memory has one write and one read port; the column walk
//   is bound by the two compares per cell.
//   The result sits in an output register; later load items are still taken
//   while it waits, and a row finishing behind a stalled result waits for it.
//   After reset the stored row is filled with the reset first row, one entry
//   a cycle, with ready low until the fill is done; APB writes are taken.
//   Configuration registers sit on the APB port at byte address 4*index.
// ----------------------------------------------------------------------------
module global_alignment_strip_scorer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    gass_in_if.sink                      i_in,
    gass_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gass_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import gass_pkg::*;

    t_cfg              cfg;
    t_state            r_state, n_state;

    logic [CNT_W-1:0]  r_col;
    logic [23:0]       r_row_cnt;
    logic [31:0]       r_acc;
    logic [7:0]        r_step;
    logic              r_is_row;
    logic [7:0]        r_base_q;
    logic [31:0]       r_left;
    logic [31:0]       r_cur, r_diag, r_best;
    logic [31:0]       r_prev_rd;
    logic [7:0]        r_ref_rd;
    logic              r_out_valid;
    logic [23:0]       r_out_row;
    logic [31:0]       r_out_score;

    logic [31:0]       prev_mem [STRIP_COLUMNS];
    logic [7:0]        ref_mem  [REF_DEPTH];

    logic              in_fire, out_free;
    logic [CNT_W-1:0]  width_m1;
    logic              col_last, fill_last;
    logic [31:0]       gap_ext, sub, head_val, best_a, col_best, mul_p;
    logic [23:0]       mul_a;
    logic              prev_we;
    logic [COL_W-1:0]  prev_waddr, prev_raddr;
    logic [CNT_W-1:0]  prev_rnext, ref_rnext;
    logic [31:0]       prev_wdata;
    logic              ref_we;
    logic [COL_W-1:0]  ref_raddr;

    gass_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.row_number  = r_out_row;
    assign o_out.right_score = r_out_score;

    always_comb begin
        if (cfg.strip_width < 7'd2) begin
            width_m1 = CNT_W'(1);
        end else if (32'(cfg.strip_width) > STRIP_COLUMNS) begin
            width_m1 = CNT_W'(STRIP_COLUMNS - 1);
        end else begin
            width_m1 = CNT_W'(cfg.strip_width - 7'd1);
        end
    end

    assign col_last  = (r_col >= width_m1);
    assign fill_last = (r_col == CNT_W'(STRIP_COLUMNS - 1));

    // shared arithmetic
    assign gap_ext  = sext8(cfg.gap_score);
    assign mul_a    = r_is_row ? r_row_cnt : cfg.strip_offset;
    assign mul_p    = {8'd0, mul_a} * gap_ext;
    assign head_val = cfg.first_strip ? r_acc : r_left;
    assign sub      = (r_ref_rd == r_base_q) ? sext8(cfg.match_score)
                                             : sext8(cfg.mismatch_score);
    assign best_a   = smax(r_diag + sub, r_prev_rd + gap_ext);
    assign col_best = smax(r_best, r_cur + gap_ext);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (i_in.kind == KIND_ROW || i_in.kind == KIND_BEGIN)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = r_is_row ? S_HEAD : S_FILL;
            S_HEAD: n_state = S_COLA;
            S_COLA: n_state = S_COLB;
            S_COLB: n_state = col_last ? S_DONE : S_COLA;
            S_DONE: n_state = out_free ? S_IDLE : S_DONE;
            S_FILL: n_state = fill_last ? S_IDLE : S_FILL;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        prev_we    = 1'b0;
        prev_waddr = COL_W'(r_col);
        prev_wdata = r_acc;
        prev_rnext = '0;
        ref_rnext  = '0;
        unique case (r_state)
            S_FILL: begin
                prev_we = 1'b1;
            end
            S_HEAD: begin
                prev_we    = 1'b1;
                prev_waddr = '0;
                prev_wdata = head_val;
                prev_rnext = CNT_W'(1);
            end
            S_COLB: begin
                prev_we    = 1'b1;
                prev_wdata = col_best;
                prev_rnext = r_col + CNT_W'(1);
                ref_rnext  = r_col;
            end
            default: ;
        endcase
    end

    assign prev_raddr = (32'(prev_rnext) < STRIP_COLUMNS) ? COL_W'(prev_rnext) : '0;
    assign ref_raddr  = (32'(ref_rnext) < REF_DEPTH) ? COL_W'(ref_rnext) : '0;
    assign ref_we     = in_fire && (i_in.kind == KIND_LOAD)
                        && (32'(i_in.ref_position) < REF_DEPTH);

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        r_prev_rd <= prev_mem[prev_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ref_we) begin
            ref_mem[COL_W'(i_in.ref_position)] <= i_in.base;
        end
        r_ref_rd <= ref_mem[ref_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_col       <= '0;
            r_acc       <= 32'd0;
            r_step      <= 8'hFF;
            r_row_cnt   <= 24'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire && i_in.kind == KIND_ROW) begin
                r_row_cnt <= r_row_cnt + 24'd1;
            end else if (in_fire && i_in.kind == KIND_BEGIN) begin
                r_row_cnt <= 24'd0;
            end
            unique case (r_state)
                S_MUL: begin
                    r_acc  <= mul_p;
                    r_step <= cfg.gap_score;
                    r_col  <= '0;
                end
                S_HEAD: r_col <= CNT_W'(1);
                S_COLB: begin
                    if (!col_last) begin
                        r_col <= r_col + CNT_W'(1);
                    end
                end
                S_FILL: begin
                    r_acc <= r_acc + sext8(r_step);
                    r_col <= r_col + CNT_W'(1);
                end
                default: ;
            endcase
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_is_row <= (i_in.kind == KIND_ROW);
            r_base_q <= i_in.base;
            r_left   <= i_in.left_score;
        end
        unique case (r_state)
            S_HEAD: begin
                r_cur  <= head_val;
                r_diag <= r_prev_rd;
            end
            S_COLA: begin
                r_best <= best_a;
                r_diag <= r_prev_rd;
            end
            S_COLB: r_cur <= col_best;
            default: ;
        endcase
        if (r_state == S_DONE && out_free) begin
            r_out_row   <= r_row_cnt;
            r_out_score <= r_cur;
        end
    end

    a_row_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.kind == KIND_ROW) |=> (r_row_cnt == $past(r_row_cnt) + 24'd1))
        else $error("row counter did not advance on a row transfer");

    a_begin_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.kind == KIND_BEGIN) |=> (r_row_cnt == 24'd0))
        else $error("row counter not cleared by begin");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside row completion");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COLA || r_state == S_COLB)
        |-> (r_col != '0 && 32'(r_col) < STRIP_COLUMNS))
        else $error("column index out of range during row walk");

endmodule
